// ----- rtl/assert_macros.svh -----
// Assertion macros for the scrubber RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/cpps_pkg.sv -----
// Types, constants and helper functions for the captured packet payload scrubber.
// Depends on nothing; used by all scrubber modules and the testbench.
package cpps_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 16384;
   localparam int MIN_OFFSET_WIDTH        = 8;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [7:0] ICMP_HEADER_BYTES     = 8'd8;
   localparam logic [7:0] UDP_HEADER_BYTES      = 8'd8;
   localparam logic [7:0] IP_PROTO_FIELD_OFFSET = 8'd9;
   localparam logic [7:0] TCP_DOFF_FIELD_OFFSET = 8'd12;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_IPV4  = 2'd1,
      CLASS_ARP   = 2'd2
   } cpps_class_type;

   typedef enum logic [1:0] {
      MODE_PASS      = 2'd0,
      MODE_ZERO      = 2'd1,
      MODE_WAIT_PROT = 2'd2,
      MODE_WAIT_TCP  = 2'd3
   } cpps_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic [1:0] frame_class;
      logic [5:0] encap_len;
   } cpps_req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } cpps_rsp_type;

   typedef struct packed {
      cpps_mode_type mode;
      logic [5:0]    link_end;
      logic [5:0]    ip_hdr_len;
      logic [7:0]    keep_end;
   } cpps_state_type;

   function automatic logic is_routing_proto(input logic [7:0] proto);
      logic hit;
      case (proto)
         8'd2, 8'd3, 8'd8, 8'd9, 8'd54, 8'd63, 8'd88, 8'd89, 8'd94: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ----- rtl/cpps_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transfer.
// Depends on nothing; payload type set per instance from cpps_pkg.
interface cpps_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/cpps_scrub_decide.sv -----
// Per-byte keep/zero decision and header tracking state update.
// Depends on cpps_pkg.
module cpps_scrub_decide #(
   parameter int OFFSET_WIDTH = cpps_pkg::MIN_OFFSET_WIDTH
) (
   input  cpps_pkg::cpps_req_type   req,
   input  logic [OFFSET_WIDTH-1:0]  offset,
   input  cpps_pkg::cpps_state_type state_cur,
   output cpps_pkg::cpps_state_type state_nxt,
   output logic                     zero_byte
);

   cpps_pkg::cpps_state_type eff;
   logic [7:0]               base;
   logic [7:0]               proto_pos;
   logic [7:0]               doff_pos;
   logic [7:0]               tcp_len;

   always_comb begin
      eff = state_cur;
      if (req.first) begin
         eff.link_end   = req.encap_len;
         eff.ip_hdr_len = '0;
         eff.keep_end   = {2'b00, req.encap_len};
         case (req.frame_class)
            cpps_pkg::CLASS_ARP:  eff.mode = cpps_pkg::MODE_PASS;
            cpps_pkg::CLASS_IPV4: eff.mode = cpps_pkg::MODE_WAIT_PROT;
            default:              eff.mode = cpps_pkg::MODE_ZERO;
         endcase
      end
   end

   assign base      = {2'b00, eff.link_end} + {2'b00, eff.ip_hdr_len};
   assign proto_pos = {2'b00, eff.link_end} + cpps_pkg::IP_PROTO_FIELD_OFFSET;
   assign doff_pos  = base + cpps_pkg::TCP_DOFF_FIELD_OFFSET;
   assign tcp_len   = {2'b00, req.data[7:4], 2'b00};

   // next state
   always_comb begin
      state_nxt = eff;
      unique case (eff.mode)
         cpps_pkg::MODE_WAIT_PROT: begin
            if (offset == OFFSET_WIDTH'({2'b00, eff.link_end})) begin
               state_nxt.ip_hdr_len = {req.data[3:0], 2'b00};
            end
            if (offset == OFFSET_WIDTH'(proto_pos)) begin
               if (cpps_pkg::is_routing_proto(req.data)) begin
                  state_nxt.mode = cpps_pkg::MODE_PASS;
               end else if (req.data == cpps_pkg::PROTO_ICMP) begin
                  state_nxt.keep_end = base + cpps_pkg::ICMP_HEADER_BYTES;
                  state_nxt.mode     = cpps_pkg::MODE_ZERO;
               end else if (req.data == cpps_pkg::PROTO_UDP) begin
                  state_nxt.keep_end = base + cpps_pkg::UDP_HEADER_BYTES;
                  state_nxt.mode     = cpps_pkg::MODE_ZERO;
               end else if (req.data == cpps_pkg::PROTO_TCP) begin
                  state_nxt.keep_end = base;
                  state_nxt.mode     = cpps_pkg::MODE_WAIT_TCP;
               end else begin
                  state_nxt.keep_end = base;
                  state_nxt.mode     = cpps_pkg::MODE_ZERO;
               end
            end
         end
         cpps_pkg::MODE_WAIT_TCP: begin
            if (offset == OFFSET_WIDTH'(doff_pos)) begin
               state_nxt.keep_end = base + tcp_len;
               state_nxt.mode     = cpps_pkg::MODE_ZERO;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      zero_byte = (eff.mode == cpps_pkg::MODE_ZERO) &&
                  (offset >= OFFSET_WIDTH'(eff.keep_end));
   end

endmodule

// ----- rtl/captured_packet_payload_scrubber.sv -----
// A byte accepted on req_if appears on rsp_if in the cycle after it is accepted.
// Throughput: one byte per cycle while rsp_if is ready; req_if is ready whenever the result register
// is empty or being drained in the same cycle, so stalls cost no bubbles.
// Reset (synchronous, active high): pass mode, offset and header state zero,
// result register empty.
`include "assert_macros.svh"
module captured_packet_payload_scrubber #(
   parameter int MAX_FRAME_BYTES = cpps_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   cpps_stream_if.sink   req_if,
   cpps_stream_if.source rsp_if
);

   localparam int FrameCountWidth = $clog2(MAX_FRAME_BYTES + 1);
   localparam int OffsetWidth     = (FrameCountWidth > cpps_pkg::MIN_OFFSET_WIDTH) ?
                                    FrameCountWidth : cpps_pkg::MIN_OFFSET_WIDTH;

   logic [OffsetWidth-1:0]   offset_ff;
   logic [OffsetWidth-1:0]   offset_in;
   logic [OffsetWidth-1:0]   offset_eff;
   cpps_pkg::cpps_state_type state_ff;
   cpps_pkg::cpps_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   cpps_pkg::cpps_rsp_type   rsp_payload_ff;
   cpps_pkg::cpps_rsp_type   rsp_payload_in;
   cpps_pkg::cpps_req_type   req;
   logic                     req_xfer;
   logic                     zero_byte;

   assign req       = req_if.payload;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer  = req_if.valid && req_if.ready;
   assign offset_eff = req.first ? '0 : offset_ff;

   cpps_scrub_decide #(
      .OFFSET_WIDTH (OffsetWidth)
   ) u_decide (
      .req       (req),
      .offset    (offset_eff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .zero_byte (zero_byte)
   );

   // saturate the offset at all ones
   assign offset_in = (&offset_eff) ? offset_eff : offset_eff + OffsetWidth'(1);

   always_comb begin
      rsp_payload_in.data_out = zero_byte ? 8'd0 : req.data;
      rsp_payload_in.last_out = req.last;
      rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         state_ff     <= '{mode: cpps_pkg::MODE_PASS, default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            offset_ff <= offset_in;
            state_ff  <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   `ASSERT_NEXT(a_arp_first_passes, clock, reset,
      req_xfer && req.first && (req.frame_class == cpps_pkg::CLASS_ARP),
      rsp_if.payload.data_out == $past(req.data))
   `ASSERT_NEXT(a_first_restarts_offset, clock, reset,
      req_xfer && req.first, offset_ff == OffsetWidth'(1))
   `ASSERT_NEXT(a_offset_advances, clock, reset,
      req_xfer && !req.first && !(&offset_ff),
      offset_ff == $past(offset_ff) + OffsetWidth'(1))
   `ASSERT_IMPLIES(a_pass_mode_keeps, clock, reset,
      req_xfer && !req.first && (state_ff.mode == cpps_pkg::MODE_PASS),
      !zero_byte)

endmodule

// ----- sim/captured_packet_payload_scrubber_tb.sv -----
// Self-checking bench for captured_packet_payload_scrubber: frame bytes are streamed
// in, each scrubbed byte is checked against a behavioural scrub predictor.
// Depends on cpps_pkg, cpps_stream_if and the scrubber RTL.
module captured_packet_payload_scrubber_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TIMEOUT_CYCLES = 200_000;
   localparam int         RANDOM_BYTES   = 350;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         REPORT_LIMIT   = 10;
   localparam logic [1:0] CLASS_SPARE    = 2'd3;
   localparam logic [7:0] ROUTING_PROTOS [9] = '{8'd2, 8'd3, 8'd8, 8'd9, 8'd54,
                                                8'd63, 8'd88, 8'd89, 8'd94};

   typedef struct {
      cpps_pkg::cpps_req_type req;
      bit                     drain;
   } feed_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpps_stream_if #(.payload_type(cpps_pkg::cpps_req_type)) req_if ();
   cpps_stream_if #(.payload_type(cpps_pkg::cpps_rsp_type)) rsp_if ();

   captured_packet_payload_scrubber u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   feed_item_type          pending_bytes [$];
   cpps_pkg::cpps_rsp_type expected_bytes [$];
   bit                     hold_for_drain = 1'b0;
   bit                     req_taken      = 1'b0;
   int                     fault_count    = 0;
   int                     cycle_count    = 0;
   int                     burst_left     = 1;
   int                     gap_left       = 0;
   int                     pattern_age    = 0;
   logic [31:0]            ready_pattern  = 32'hFFFF_FFFF;

   // scrub predictor state
   int                      frame_pos;
   logic [5:0]              link_end;
   logic [5:0]              hdr_len;
   logic [7:0]              keep_from;
   cpps_pkg::cpps_mode_type mode;

   function automatic cpps_pkg::cpps_rsp_type scrub_predict(input cpps_pkg::cpps_req_type b);
      cpps_pkg::cpps_rsp_type r;
      int                     pos;
      bit                     routed;
      routed = 1'b0;
      if (b.first) begin
         frame_pos = 0;
         link_end  = b.encap_len;
         hdr_len   = '0;
         keep_from = {2'b00, b.encap_len};
         case (b.frame_class)
            cpps_pkg::CLASS_ARP:  mode = cpps_pkg::MODE_PASS;
            cpps_pkg::CLASS_IPV4: mode = cpps_pkg::MODE_WAIT_PROT;
            default:              mode = cpps_pkg::MODE_ZERO;
         endcase
      end
      pos = frame_pos;
      r.data_out = (mode == cpps_pkg::MODE_ZERO && pos >= keep_from) ? 8'h00 : b.data;
      r.last_out = b.last;
      if (mode == cpps_pkg::MODE_WAIT_PROT) begin
         if (pos == link_end)
            hdr_len = {b.data[3:0], 2'b00};
         if (pos == link_end + cpps_pkg::IP_PROTO_FIELD_OFFSET) begin
            foreach (ROUTING_PROTOS[k])
               if (b.data == ROUTING_PROTOS[k])
                  routed = 1'b1;
            if (routed) begin
               mode = cpps_pkg::MODE_PASS;
            end else if (b.data == cpps_pkg::PROTO_ICMP) begin
               keep_from = link_end + hdr_len + cpps_pkg::ICMP_HEADER_BYTES;
               mode      = cpps_pkg::MODE_ZERO;
            end else if (b.data == cpps_pkg::PROTO_UDP) begin
               keep_from = link_end + hdr_len + cpps_pkg::UDP_HEADER_BYTES;
               mode      = cpps_pkg::MODE_ZERO;
            end else if (b.data == cpps_pkg::PROTO_TCP) begin
               keep_from = link_end + hdr_len;
               mode      = cpps_pkg::MODE_WAIT_TCP;
            end else begin
               keep_from = link_end + hdr_len;
               mode      = cpps_pkg::MODE_ZERO;
            end
         end
      end else if (mode == cpps_pkg::MODE_WAIT_TCP) begin
         if (pos == link_end + hdr_len + cpps_pkg::TCP_DOFF_FIELD_OFFSET) begin
            keep_from = link_end + hdr_len + {b.data[7:4], 2'b00};
            mode      = cpps_pkg::MODE_ZERO;
         end
      end
      if (frame_pos < 32'hFFFF)
         frame_pos++;
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] d, input bit f, input bit l,
                            input logic [1:0] c, input logic [5:0] e);
      feed_item_type item;
      item.req.data        = d;
      item.req.first       = f;
      item.req.last        = l;
      item.req.frame_class = c;
      item.req.encap_len   = e;
      item.drain           = hold_for_drain;
      hold_for_drain       = 1'b0;
      pending_bytes.push_back(item);
   endtask

   task automatic add_frame(input int cls, input int encap, input int len, input int ihl,
                            input int proto, input int doff, input bit close);
      logic [7:0] d;
      int         tcp_at;
      tcp_at = encap + ihl * 4 + cpps_pkg::TCP_DOFF_FIELD_OFFSET;
      for (int i = 0; i < len; i++) begin
         d = 8'($urandom);
         if (cls == cpps_pkg::CLASS_IPV4) begin
            if (i == encap)
               d[3:0] = 4'(ihl);
            if (i == encap + cpps_pkg::IP_PROTO_FIELD_OFFSET)
               d = 8'(proto);
            if (i == tcp_at)
               d[7:4] = 4'(doff);
         end
         if (i == 0)
            push_byte(d, 1'b1, close && len == 1, 2'(cls), 6'(encap));
         else
            push_byte(d, 1'b0, close && i == len - 1, 2'($urandom), 6'($urandom));
      end
   endtask

   // stimulus
   initial begin
      int kind, cls, encap, ihl, doff, proto, keep, need, len, target;
      bit well_formed;

      push_byte(8'hFF, 1'b0, 1'b0, cpps_pkg::CLASS_IPV4, 6'd0);
      push_byte(8'h00, 1'b0, 1'b1, cpps_pkg::CLASS_OTHER, 6'd0);
      push_byte(8'hFF, 1'b1, 1'b0, cpps_pkg::CLASS_ARP, 6'd0);
      push_byte(8'h00, 1'b0, 1'b0, cpps_pkg::CLASS_OTHER, 6'd63);
      push_byte(8'hFF, 1'b0, 1'b1, CLASS_SPARE, 6'd63);
      push_byte(8'hFF, 1'b1, 1'b0, cpps_pkg::CLASS_OTHER, 6'd0);
      push_byte(8'hFF, 1'b0, 1'b1, cpps_pkg::CLASS_IPV4, 6'd63);
      push_byte(8'hFF, 1'b1, 1'b0, CLASS_SPARE, 6'd63);
      push_byte(8'h00, 1'b0, 1'b1, cpps_pkg::CLASS_ARP, 6'd0);
      push_byte(8'hFF, 1'b1, 1'b1, cpps_pkg::CLASS_OTHER, 6'd1);
      add_frame(cpps_pkg::CLASS_IPV4, 2, 6, 5, cpps_pkg::PROTO_UDP, 5, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b0, cpps_pkg::CLASS_ARP, 6'd63);
      push_byte(8'hFF, 1'b0, 1'b1, cpps_pkg::CLASS_OTHER, 6'd0);

      hold_for_drain = 1'b1;
      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         kind  = $urandom_range(0, 9);
         encap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
         if (kind < 7) begin
            well_formed = $urandom_range(0, 3) != 0;
            ihl  = well_formed ? $urandom_range(5, 6) : $urandom_range(0, 15);
            doff = well_formed ? $urandom_range(5, 6) : $urandom_range(0, 15);
            case ($urandom_range(0, 4))
               0:       proto = cpps_pkg::PROTO_ICMP;
               1:       proto = cpps_pkg::PROTO_UDP;
               2:       proto = cpps_pkg::PROTO_TCP;
               3:       proto = ROUTING_PROTOS[$urandom_range(0, 8)];
               default: proto = $urandom_range(0, 255);
            endcase
            keep = encap + ihl * 4;
            if (proto == cpps_pkg::PROTO_ICMP || proto == cpps_pkg::PROTO_UDP)
               keep += cpps_pkg::ICMP_HEADER_BYTES;
            else if (proto == cpps_pkg::PROTO_TCP)
               keep += doff * 4;
            need = encap + cpps_pkg::IP_PROTO_FIELD_OFFSET + 1;
            if (proto == cpps_pkg::PROTO_TCP &&
                encap + ihl * 4 + cpps_pkg::TCP_DOFF_FIELD_OFFSET + 1 > need)
               need = encap + ihl * 4 + cpps_pkg::TCP_DOFF_FIELD_OFFSET + 1;
            if (keep > need)
               need = keep;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, need)
                                               : need + $urandom_range(0, 6);
            add_frame(cpps_pkg::CLASS_IPV4, encap, len, ihl, proto, doff,
                      $urandom_range(0, 9) != 0);
         end else begin
            case ($urandom_range(0, 2))
               0:       cls = cpps_pkg::CLASS_ARP;
               1:       cls = cpps_pkg::CLASS_OTHER;
               default: cls = CLASS_SPARE;
            endcase
            add_frame(cls, encap, $urandom_range(1, encap + 6), 0, 0, 0,
                      $urandom_range(0, 9) != 0);
         end
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
               push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 2'($urandom),
                         6'($urandom));
      end

      hold_for_drain = 1'b1;
      add_frame(cpps_pkg::CLASS_IPV4, 0, 40, 5, cpps_pkg::PROTO_TCP, 5, 1'b1);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_bytes.size() == 0)
         $display("** captured_packet_payload_scrubber: PASSED **");
      else
         $display("** captured_packet_payload_scrubber: FAILED **");
      $finish;
   end

   // byte driver: bursts with random gaps, hold until transfer
   always @(negedge clock) begin
      feed_item_type nxt;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_bytes.size() == 0 ||
                      (pending_bytes[0].drain && expected_bytes.size() != 0)) begin
            req_if.valid <= 1'b0;
         end else begin
            nxt = pending_bytes.pop_front();
            req_if.payload <= nxt.req;
            req_if.valid   <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // result sink: rotate a ready pattern, swap it now and then
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern = 32'hFFFF_FFFF;
               1:       ready_pattern = $urandom | 32'h1;
               default: ready_pattern = ($urandom & $urandom) | 32'h1;
            endcase
            pattern_age = $urandom_range(50, 400);
         end
         pattern_age--;
         rsp_if.ready  <= ready_pattern[0];
         ready_pattern  = {ready_pattern[0], ready_pattern[31:1]};
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      cpps_pkg::cpps_rsp_type want;
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("** captured_packet_payload_scrubber: FAILED **");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
         frame_pos  = 0;
         link_end   = '0;
         hdr_len    = '0;
         keep_from  = '0;
         mode       = cpps_pkg::MODE_PASS;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_bytes.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected transfer: data_out=%02h last_out=%0b",
                           rsp_if.payload.data_out, rsp_if.payload.last_out);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.payload.data_out !== want.data_out ||
                   rsp_if.payload.last_out !== want.last_out) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("mismatch: data_out exp %02h got %02h, last_out exp %0b got %0b",
                              want.data_out, rsp_if.payload.data_out,
                              want.last_out, rsp_if.payload.last_out);
               end
            end
         end
         if (req_if.valid && req_if.ready)
            expected_bytes.push_back(scrub_predict(req_if.payload));
      end
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cpps_pkg.sv
rtl/cpps_stream_if.sv
rtl/cpps_scrub_decide.sv
rtl/captured_packet_payload_scrubber.sv
sim/captured_packet_payload_scrubber_tb.sv
